// ===== design/udse_pkg.sv =====
// ----------------------------------------------------------------------------
// udse_pkg
// Shared types and constants for the U-disparity segment extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package udse_pkg;

  // Histogram geometry.
  localparam int IMG_WIDTH = 512;
  localparam int BINS      = 128;
  localparam int COL_W     = $clog2(IMG_WIDTH);
  localparam int ROW_W     = $clog2(BINS);
  localparam int ADDR_W    = ROW_W + COL_W;

  // Field and register widths.
  localparam int DISP_W    = 8;
  localparam int COLUMN_W  = 9;
  localparam int BINROW_W  = 7;
  localparam int CNT_W     = 8;
  localparam int SUM_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Register reset values.
  localparam logic [DISP_W-1:0] DISP_LIMIT_RST = DISP_W'(64);
  localparam logic [CNT_W-1:0]  CNT_THR_RST    = CNT_W'(6);
  localparam logic [SUM_W-1:0]  SUM_THR_RST    = SUM_W'(128);

  // Item operations.
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CNT_THR    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_THR    = CFG_IDX_W'(2);

  // Top-level control states.
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // One item in the read-modify-write stage.
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [COLUMN_W-1:0] column;
    logic [BINROW_W-1:0] row;
  } stage_t;

  // One emitted segment.
  typedef struct packed {
    logic [BINROW_W-1:0] row;
    logic [COLUMN_W-1:0] start;
    logic [COLUMN_W-1:0] stop;
  } seg_t;

endpackage

`default_nettype wire

// ===== design/udisparity_segment_extract_top.sv =====
// ----------------------------------------------------------------------------
// udisparity_segment_extract_top
// U-disparity histogram with horizontal obstacle segment extraction.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the whole histogram memory,
// one cell per cycle, over all BINS * 2**COL_W = 65536 cells, and accepts no item
// until it is done (configuration writes are taken at any time). After that
// it takes one item per cycle unless stalled: the item's cell is read from a
// single-port-write, single-port-read memory with a registered read, and is
// updated and written back in the following cycle, with the last write
// forwarded to a read of the same cell. Segments go through a two-beat
// output queue; the input stalls whenever the queue holds one result and an
// item is in the update stage, or the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module udisparity_segment_extract_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Item input
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              operation,
  input  wire logic [udse_pkg::DISP_W-1:0]       disparity,
  input  wire logic [udse_pkg::COLUMN_W-1:0]     column,
  input  wire logic [udse_pkg::BINROW_W-1:0]     bin_row,
  // Segment output
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [udse_pkg::BINROW_W-1:0]          seg_row,
  output logic [udse_pkg::COLUMN_W-1:0]          seg_start,
  output logic [udse_pkg::COLUMN_W-1:0]          seg_end,
  // Configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [udse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [udse_pkg::CFG_DAT_W-1:0]    cfg_data
);

  import udse_pkg::*;

  // Configuration registers.
  logic [DISP_W-1:0] disp_limit;
  logic [CNT_W-1:0]  cnt_thr;
  logic [SUM_W-1:0]  sum_thr;

  // Control state and clearing pass.
  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              run_en;

  // Update stage, memory and forwarding.
  stage_t            s1;
  stage_t            s1_next;
  logic [CNT_W-1:0]  mem [0:(2**ADDR_W)-1];
  logic [CNT_W-1:0]  rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [CNT_W-1:0]  wd;
  logic              last_we;
  logic [ADDR_W-1:0] last_addr;
  logic [CNT_W-1:0]  last_data;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_new;

  // Run tracking.
  logic [SUM_W-1:0]    run_sum, run_sum_next;
  logic [COLUMN_W-1:0] run_start, run_start_next;
  logic                run_open, run_open_next;
  logic [SUM_W-1:0]    base_sum;
  logic [COLUMN_W-1:0] base_start;
  logic                base_open;
  logic [SUM_W:0]      sum_wide;
  logic                emit;

  // Output queue.
  seg_t        q [0:1];
  logic        q_wr_ptr;
  logic        q_rd_ptr;
  logic [1:0]  q_count;
  logic        q_push;
  logic        q_pop;

  logic        in_take;
  logic        col_ok;
  logic        disp_ok;
  logic        row_ok;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_limit <= DISP_LIMIT_RST;
      cnt_thr    <= CNT_THR_RST;
      sum_thr    <= SUM_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DISP_LIMIT: disp_limit <= cfg_data[DISP_W-1:0];
        CFG_CNT_THR:    cnt_thr    <= cfg_data[CNT_W-1:0];
        CFG_SUM_THR:    sum_thr    <= cfg_data[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Next-state logic: clear the memory once, then run.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    case (state)
      ST_RUN:  run_en = 1'b1;
      default: run_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (!run_en) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Input acceptance leaves room in the queue for every item in flight.
  assign in_ready = run_en && ((q_count + {1'b0, s1.valid}) < 2'd2);
  assign in_take  = in_valid && in_ready;

  // Decode the incoming item.
  always_comb begin
    col_ok  = 32'(column) < IMG_WIDTH;
    disp_ok = (disparity < disp_limit) && (32'(disparity) < BINS);
    row_ok  = 32'(bin_row) < BINS;
    s1_next.op     = op_t'(operation);
    s1_next.column = column;
    s1_next.row    = bin_row;
    if (op_t'(operation) == OP_ADD) begin
      s1_next.valid = in_take && col_ok && disp_ok;
      s1_next.addr  = {ROW_W'(disparity), COL_W'(column)};
    end else begin
      s1_next.valid = in_take && col_ok && row_ok;
      s1_next.addr  = {ROW_W'(bin_row), COL_W'(column)};
    end
  end

  assign rd_addr = s1_next.addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= s1_next.valid;
    end
    s1.op     <= s1_next.op;
    s1.addr   <= s1_next.addr;
    s1.column <= s1_next.column;
    s1.row    <= s1_next.row;
  end

  // Histogram memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  // Remember the last write so a read issued in the same cycle sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_we <= 1'b0;
    end else begin
      last_we <= we;
    end
    last_addr <= wa;
    last_data <= wd;
  end

  // Read-modify-write of the cell in the update stage.
  always_comb begin
    cnt = (last_we && (last_addr == s1.addr)) ? last_data : rdata;
    if (s1.op == OP_ADD) begin
      cnt_new = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    end else begin
      cnt_new = '0;
    end
    if (!run_en) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else begin
      we = s1.valid;
      wa = s1.addr;
      wd = cnt_new;
    end
  end

  // Run tracking for scan items.
  always_comb begin
    if (s1.column == '0) begin
      base_sum   = '0;
      base_start = '0;
      base_open  = 1'b0;
    end else begin
      base_sum   = run_sum;
      base_start = run_start;
      base_open  = run_open;
    end
    sum_wide       = {1'b0, base_sum} + (SUM_W+1)'(cnt);
    run_sum_next   = run_sum;
    run_start_next = run_start;
    run_open_next  = run_open;
    emit           = 1'b0;
    if (s1.valid && (s1.op == OP_SCAN)) begin
      if (cnt >= cnt_thr) begin
        run_sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        run_open_next  = 1'b1;
        run_start_next = base_open ? base_start : s1.column;
      end else begin
        emit           = base_open && (base_sum > sum_thr) && (s1.row != '0);
        run_sum_next   = '0;
        run_start_next = '0;
        run_open_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum   <= '0;
      run_start <= '0;
      run_open  <= 1'b0;
    end else begin
      run_sum   <= run_sum_next;
      run_start <= run_start_next;
      run_open  <= run_open_next;
    end
  end

  // Two-beat output queue.
  assign q_push = emit;
  assign q_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q[q_wr_ptr].row   <= s1.row;
      q[q_wr_ptr].start <= base_start;
      q[q_wr_ptr].stop  <= s1.column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= 1'b0;
      q_rd_ptr <= 1'b0;
      q_count  <= '0;
    end else begin
      if (q_push) q_wr_ptr <= ~q_wr_ptr;
      if (q_pop)  q_rd_ptr <= ~q_rd_ptr;
      case ({q_push, q_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  assign out_valid = (q_count != '0);
  assign seg_row   = q[q_rd_ptr].row;
  assign seg_start = q[q_rd_ptr].start;
  assign seg_end   = q[q_rd_ptr].stop;

endmodule

`default_nettype wire

// ===== dv/udisparity_segment_extract_top_tb.sv =====
// ----------------------------------------------------------------------------
// udisparity_segment_extract_top_tb
// Self-checking bench for the U-disparity segment extractor. A short table of
// directed beats covers field extremes, ignored pixels, row zero, the column
// zero restart and read-and-clear against a just-written cell. Random row
// sweeps then fill histogram cells and scan them back under several register
// settings. A short pass saturates a cell count. Segments are compared with
// a shadow histogram kept inside the bench or with typed expectations.
// ----------------------------------------------------------------------------
`default_nettype none

module udisparity_segment_extract_top_tb;
  import udse_pkg::*;

  // Beats the directed table holds.
  localparam int DIR_ROWS = 24;
  // Cycles to wait for outstanding segments, then for the pipeline to empty.
  localparam int DRAIN_CYCLES = 5000;
  localparam int TAIL_CYCLES  = 8;
  // About 1800 beats with sender gaps and output stalls, plus the clearing
  // pass and the drains, taken several times over.
  localparam longint unsigned LIMIT_UNITS = 64'd20_000_000;

  // The unused register index; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  localparam seg_t SEG_NONE = '0;

  // How a directed beat is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_SEG
  } chk_t;

  // Output-side stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_SPARSE
  } rx_mode_t;

  typedef struct packed {
    op_t                 op;
    logic [DISP_W-1:0]   disp;
    logic [COLUMN_W-1:0] col;
    logic [BINROW_W-1:0] row;
    chk_t                chk;
    seg_t                seg;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 operation = 1'b0;
  logic [DISP_W-1:0]    disparity = '0;
  logic [COLUMN_W-1:0]  column    = '0;
  logic [BINROW_W-1:0]  bin_row   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BINROW_W-1:0]  seg_row;
  logic [COLUMN_W-1:0]  seg_start;
  logic [COLUMN_W-1:0]  seg_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // Shadow histogram, run tracker and register copies.
  logic [CNT_W-1:0]    cell_counts [0:BINS*IMG_WIDTH-1];
  logic [SUM_W-1:0]    span_sum;
  logic [COLUMN_W-1:0] span_first;
  logic                span_live;
  logic [DISP_W-1:0]   lim_disp;
  logic [CNT_W-1:0]    thr_count;
  logic [SUM_W-1:0]    thr_sum;

  seg_t        pending_segments [$];
  probe_t      dir_table [0:DIR_ROWS-1];
  int unsigned items_fed  = 0;
  int unsigned segs_seen  = 0;
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned rx_tick    = 0;
  rx_mode_t    rx_mode    = RX_OPEN;

  udisparity_segment_extract_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .disparity (disparity),
    .column    (column),
    .bin_row   (bin_row),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .seg_row   (seg_row),
    .seg_start (seg_start),
    .seg_end   (seg_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen)
      note_failure($sformatf("%s mismatch: expected %0d, actual %0d", name, want, seen));
  endfunction

  function automatic void close_span();
    span_sum   = '0;
    span_first = '0;
    span_live  = 1'b0;
  endfunction

  // Applies one beat to the shadow histogram. Returns 1 with the segment
  // when a qualifying run closes.
  function automatic bit advance_histogram(input op_t op, input logic [DISP_W-1:0] disp,
                                           input logic [COLUMN_W-1:0] col,
                                           input logic [BINROW_W-1:0] row,
                                           output seg_t seg);
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W:0]    sum_next;
    seg = SEG_NONE;
    if (op == OP_ADD) begin
      if (disp >= lim_disp || disp >= BINS) return 1'b0;
      addr = {disp[ROW_W-1:0], col};
      if (cell_counts[addr] != CNT_MAX) cell_counts[addr] = cell_counts[addr] + 1'b1;
      return 1'b0;
    end
    // Scan: read the cell and clear it.
    addr = {row, col};
    cnt = cell_counts[addr];
    cell_counts[addr] = '0;
    if (col == 0) close_span();
    if (cnt >= thr_count) begin
      sum_next = {1'b0, span_sum} + (SUM_W+1)'(cnt);
      span_sum = (sum_next > SUM_MAX) ? SUM_MAX : sum_next[SUM_W-1:0];
      if (!span_live) begin
        span_live  = 1'b1;
        span_first = col;
      end
      return 1'b0;
    end
    // The run closes here; row zero never reports.
    if (span_live && span_sum > thr_sum && row != 0) begin
      seg.row   = row;
      seg.start = span_first;
      seg.stop  = col;
      close_span();
      return 1'b1;
    end
    close_span();
    return 1'b0;
  endfunction

  // Sends one beat, keeps the shadow in step and queues the segment it is checked for.
  task automatic feed_item(input op_t op, input logic [DISP_W-1:0] disp,
                           input logic [COLUMN_W-1:0] col, input logic [BINROW_W-1:0] row,
                           input chk_t chk, input seg_t typed);
    seg_t        got;
    bit          emitted;
    int unsigned gap;
    in_valid  <= 1'b1;
    operation <= op;
    disparity <= disp;
    column    <= col;
    bin_row   <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_fed++;
    emitted = advance_histogram(op, disp, col, row, got);
    if (chk == CHK_SEG) pending_segments.push_back(typed);
    else if (chk == CHK_MODEL && emitted) pending_segments.push_back(got);
    // Bursts of random length, mostly short, now and then a long steady one.
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // One register beat. Valid stays high for a following beat.
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DISP_LIMIT: lim_disp  = data[DISP_W-1:0];
      CFG_CNT_THR:    thr_count = data[CNT_W-1:0];
      CFG_SUM_THR:    thr_sum   = data[SUM_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all registers; upper data bits of the narrow ones carry junk.
  task automatic write_regs(input logic [DISP_W-1:0] max_d, input logic [CNT_W-1:0] cthr,
                            input logic [SUM_W-1:0] sthr);
    cfg_beat(CFG_DISP_LIMIT, {10'($urandom), max_d});
    cfg_beat(CFG_CNT_THR, {10'($urandom), cthr});
    cfg_beat(CFG_SUM_THR, sthr);
    cfg_beat(CFG_SPARE, 18'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Idles the input and waits until every expected segment has come out.
  task automatic quiesce();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_segments.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Scans one cell, sometimes after a stray scan somewhere else.
  task automatic scan_cell(input int unsigned r, input int unsigned c);
    if ($urandom_range(0, 19) == 0)
      feed_item(OP_SCAN, 8'($urandom), 9'($urandom), 7'($urandom), CHK_MODEL, SEG_NONE);
    feed_item(OP_SCAN, 8'($urandom), 9'(c), 7'(r), CHK_MODEL, SEG_NONE);
  endtask

  // Adds k pixels to one cell, with the odd pixel landing anywhere.
  task automatic add_pixels(input int unsigned r, input int unsigned c, input int unsigned k);
    repeat (k) begin
      if ($urandom_range(0, 9) == 0)
        feed_item(OP_ADD, 8'($urandom), 9'($urandom), 7'($urandom), CHK_MODEL, SEG_NONE);
      feed_item(OP_ADD, 8'(r), 9'(c), 7'($urandom), CHK_MODEL, SEG_NONE);
    end
  endtask

  // Fills a stretch of one histogram row and scans it back.
  task automatic sweep_row();
    int unsigned r;
    int unsigned lim;
    int unsigned base;
    int unsigned width;
    int unsigned top;
    bit          mixed;
    lim = (lim_disp > BINS) ? BINS : lim_disp;
    if (lim > 1 && $urandom_range(0, 9) < 7) r = $urandom_range(1, lim - 1);
    else if ($urandom_range(0, 2) == 0) r = 0;
    else r = $urandom_range(0, BINS - 1);
    width = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 80) : $urandom_range(2, 24);
    base  = $urandom_range(1, IMG_WIDTH - width);
    top   = (thr_count == 0) ? 2 : ((thr_count > 4) ? 9 : 2 * thr_count + 1);
    mixed = 1'($urandom_range(0, 1));
    // Most sweeps restart the row at column 0; the rest carry a run over.
    if ($urandom_range(0, 4) != 0) scan_cell(r, 0);
    // Mixed sweeps scan each cell right after its last pixel.
    for (int i = 0; i < width; i++) begin
      add_pixels(r, base + i, $urandom_range(0, top));
      if (mixed) scan_cell(r, base + i);
    end
    if (!mixed)
      for (int i = 0; i < width; i++) scan_cell(r, base + i);
    if ($urandom_range(0, 2) != 0 && base + width < IMG_WIDTH) scan_cell(r, base + width);
  endtask

  // One register setting followed by random sweeps.
  task automatic run_phase(input logic [DISP_W-1:0] max_d, input logic [CNT_W-1:0] cthr,
                           input logic [SUM_W-1:0] sthr, input int unsigned quota,
                           input int unsigned want_segs);
    int unsigned first;
    quiesce();
    write_regs(max_d, cthr, sthr);
    first = items_fed;
    while (((items_fed - first) < quota || segs_seen < want_segs) &&
           (items_fed - first) < 4 * quota)
      sweep_row();
  endtask

  // Directed beats, run with disparity limit 128, count threshold 1, sum threshold 0.
  initial begin
    //              op       disp    col      row      check      segment
    dir_table[0]  = {OP_ADD,  8'd0,   9'd0,   7'h7F,  CHK_QUIET, SEG_NONE};
    dir_table[1]  = {OP_ADD,  8'd0,   9'd1,   7'h55,  CHK_QUIET, SEG_NONE};
    // Row zero opens and closes a run but never reports it.
    dir_table[2]  = {OP_SCAN, 8'hFF,  9'd0,   7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[3]  = {OP_SCAN, 8'hAA,  9'd1,   7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[4]  = {OP_SCAN, 8'h55,  9'd2,   7'd0,   CHK_QUIET, SEG_NONE};
    // Top bin counts; disparities at or past the bin count are dropped.
    dir_table[5]  = {OP_ADD,  8'd127, 9'd4,   7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[6]  = {OP_ADD,  8'd255, 9'd5,   7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[7]  = {OP_ADD,  8'd128, 9'd5,   7'h7F,  CHK_QUIET, SEG_NONE};
    dir_table[8]  = {OP_SCAN, 8'hFF,  9'd0,   7'd127, CHK_QUIET, SEG_NONE};
    dir_table[9]  = {OP_SCAN, 8'h00,  9'd4,   7'd127, CHK_QUIET, SEG_NONE};
    dir_table[10] = {OP_SCAN, 8'h80,  9'd5,   7'd127, CHK_SEG,   {7'd127, 9'd4, 9'd5}};
    // A run open at the end of a row is dropped by the next column 0.
    dir_table[11] = {OP_ADD,  8'd1,   9'd511, 7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[12] = {OP_ADD,  8'd1,   9'd510, 7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[13] = {OP_SCAN, 8'd0,   9'd0,   7'd1,   CHK_QUIET, SEG_NONE};
    dir_table[14] = {OP_SCAN, 8'd0,   9'd510, 7'd1,   CHK_QUIET, SEG_NONE};
    dir_table[15] = {OP_SCAN, 8'd0,   9'd511, 7'd1,   CHK_QUIET, SEG_NONE};
    dir_table[16] = {OP_SCAN, 8'd0,   9'd0,   7'd1,   CHK_QUIET, SEG_NONE};
    dir_table[17] = {OP_SCAN, 8'd0,   9'd1,   7'd1,   CHK_QUIET, SEG_NONE};
    // Back-to-back updates of one cell, then a repeated scan sees it cleared.
    dir_table[18] = {OP_ADD,  8'd2,   9'd300, 7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[19] = {OP_ADD,  8'd2,   9'd300, 7'd0,   CHK_QUIET, SEG_NONE};
    dir_table[20] = {OP_SCAN, 8'd0,   9'd299, 7'd2,   CHK_QUIET, SEG_NONE};
    dir_table[21] = {OP_SCAN, 8'd0,   9'd300, 7'd2,   CHK_QUIET, SEG_NONE};
    dir_table[22] = {OP_SCAN, 8'd0,   9'd300, 7'd2,   CHK_SEG,   {7'd2, 9'd300, 9'd300}};
    dir_table[23] = {OP_SCAN, 8'd0,   9'd300, 7'd2,   CHK_QUIET, SEG_NONE};
  end

  // Output stalls: the pattern is redrawn each time the tick counter's low bits wrap to zero.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: out_ready <= (rx_tick[1:0] != 2'd3);
      default:   out_ready <= (rx_tick[2:0] == 3'd0);
    endcase
  end

  // Compare each segment beat with the oldest expectation.
  always @(posedge clk) begin : seg_check
    seg_t want;
    if (!rst && out_valid && out_ready) begin
      segs_seen++;
      if (pending_segments.size() == 0) begin
        note_failure($sformatf("segment row %0d start %0d end %0d with none expected",
                               seg_row, seg_start, seg_end));
      end else begin
        want = pending_segments.pop_front();
        check_field("seg_row", 32'(want.row), 32'(seg_row));
        check_field("seg_start", 32'(want.start), 32'(seg_start));
        check_field("seg_end", 32'(want.stop), 32'(seg_end));
      end
    end
  end

  initial begin
    for (int a = 0; a < BINS * IMG_WIDTH; a++) cell_counts[a] = '0;
    close_span();
    lim_disp  = DISP_LIMIT_RST;
    thr_count = CNT_THR_RST;
    thr_sum   = SUM_THR_RST;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed beats.
    write_regs(8'd128, 8'd1, 18'd0);
    for (int i = 0; i < DIR_ROWS; i++)
      feed_item(dir_table[i].op, dir_table[i].disp, dir_table[i].col, dir_table[i].row,
                dir_table[i].chk, dir_table[i].seg);

    // Random sweeps under several settings, extremes among them.
    run_phase(8'd128, 8'd1, 18'd0, 220, 0);
    run_phase(8'd32, 8'd2, 18'd6, 260, 0);
    run_phase(8'd1, 8'd0, 18'd262143, 200, 0);
    run_phase(8'd100, 8'd3, 18'd20, 260, 0);

    // Saturation: one cell takes three pixels past its 255 ceiling. Only a
    // clamped count joins a run at threshold 255 and clears a sum threshold
    // of 254.
    quiesce();
    write_regs(8'd128, 8'd255, 18'd254);
    repeat (258) feed_item(OP_ADD, 8'd12, 9'd1, 7'($urandom), CHK_QUIET, SEG_NONE);
    feed_item(OP_SCAN, 8'hA5, 9'd0, 7'd12, CHK_QUIET, SEG_NONE);
    feed_item(OP_SCAN, 8'h5A, 9'd1, 7'd12, CHK_QUIET, SEG_NONE);
    feed_item(OP_SCAN, 8'hA5, 9'd2, 7'd12, CHK_SEG, {7'd12, 9'd1, 9'd2});

    // Last random setting.
    run_phase(8'($urandom_range(2, 128)), 8'($urandom_range(1, 4)),
              18'($urandom_range(0, 30)), 320, 0);

    quiesce();
    if (pending_segments.size() != 0)
      note_failure($sformatf("%0d expected segments never arrived", pending_segments.size()));
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT_UNITS);
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
